@@ rtl/irpd_pkg.sv @@
`timescale 1ns / 1ps
// Types and constants for the infrared pulse-distance encoder.
// No dependencies; the RTL files refer to it by scoped names.
package irpd_pkg;

	localparam int DUR_W = 16;
	localparam int BYTE_W = 8;
	localparam int MODE_W = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int SEG_W = 5;

	localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RAW = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WAKE = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_MARK = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SPACE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ONE_MARK = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ONE_SPACE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MARK = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_SPACE = 3'd5;

	localparam logic [DUR_W-1:0] RST_HEADER_MARK = 16'd3650;
	localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd1623;
	localparam logic [DUR_W-1:0] RST_ONE_MARK = 16'd428;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE = 16'd1280;
	localparam logic [DUR_W-1:0] RST_ZERO_MARK = 16'd428;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 16'd428;

	// segment positions within a byte, raw or wake run
	localparam logic [SEG_W-1:0] SEG_HDR_MARK = 5'd0;
	localparam logic [SEG_W-1:0] SEG_CELL_FIRST = 5'd2;
	localparam logic [SEG_W-1:0] SEG_CELL_LAST = 5'd17;
	localparam logic [SEG_W-1:0] SEG_TRAILER_SPACE = 5'd19;
	localparam logic [SEG_W-1:0] SEG_RAW_DATA = 5'd0;
	localparam logic [SEG_W-1:0] SEG_RAW_CLOSE = 5'd1;
	localparam logic [SEG_W-1:0] SEG_WAKE_FIRST = 5'd0;
	localparam logic [SEG_W-1:0] SEG_WAKE_LAST = 5'd10;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_RAW,
		KIND_WAKE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [BYTE_W-1:0] data_byte;
		logic [DUR_W-1:0] raw_duration;
		logic raw_level;
		logic first_item;
		logic last_item;
	} cmd_t;

	typedef struct packed {
		logic [DUR_W-1:0] header_mark;
		logic [DUR_W-1:0] header_space;
		logic [DUR_W-1:0] one_mark;
		logic [DUR_W-1:0] one_space;
		logic [DUR_W-1:0] zero_mark;
		logic [DUR_W-1:0] zero_space;
	} cfg_t;

endpackage

@@ rtl/irpd_intf.sv @@
`timescale 1ns / 1ps
// Channel interfaces: input items, output segments and register writes.
// Depends on irpd_pkg.
interface irpd_in_if;
	logic valid;
	logic ready;
	logic [irpd_pkg::MODE_W-1:0] mode;
	logic [irpd_pkg::BYTE_W-1:0] data_byte;
	logic [irpd_pkg::DUR_W-1:0] raw_duration;
	logic first_item;
	logic last_item;

	modport source (output valid, mode, data_byte, raw_duration, first_item, last_item,
		input ready);
	modport sink (input valid, mode, data_byte, raw_duration, first_item, last_item,
		output ready);
endinterface

interface irpd_out_if;
	logic valid;
	logic ready;
	logic level;
	logic [irpd_pkg::DUR_W-1:0] duration;
	logic run_end;

	modport source (output valid, level, duration, run_end, input ready);
	modport sink (input valid, level, duration, run_end, output ready);
endinterface

interface irpd_cfg_if;
	logic valid;
	logic ready;
	logic [irpd_pkg::CFG_INDEX_W-1:0] index;
	logic [irpd_pkg::DUR_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/irpd_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input beats, tracks raw mark/space phase, builds commands.
// Depends on irpd_pkg and irpd_intf.
module irpd_front (
	input  logic clk,
	input  logic arst_n,
	irpd_in_if.sink item_in,
	output logic push_valid,
	input  logic push_ready,
	output irpd_pkg::cmd_t push_cmd
);

	logic raw_phase_odd_q;
	logic phase_eff;
	logic accept;
	logic mode_ok;

	assign item_in.ready = push_ready;
	assign accept = item_in.valid && push_ready;
	assign mode_ok = (item_in.mode == irpd_pkg::MODE_BYTE) ||
		(item_in.mode == irpd_pkg::MODE_RAW) || (item_in.mode == irpd_pkg::MODE_WAKE);
	// unused mode code is taken and dropped
	assign push_valid = item_in.valid && mode_ok;

	assign phase_eff = item_in.first_item ? 1'b0 : raw_phase_odd_q;

	always_comb begin
		case (item_in.mode)
			irpd_pkg::MODE_BYTE: push_cmd.kind = irpd_pkg::KIND_BYTE;
			irpd_pkg::MODE_RAW: push_cmd.kind = irpd_pkg::KIND_RAW;
			default: push_cmd.kind = irpd_pkg::KIND_WAKE;
		endcase
		push_cmd.data_byte = item_in.data_byte;
		push_cmd.raw_duration = item_in.raw_duration;
		push_cmd.raw_level = ~phase_eff;
		push_cmd.first_item = item_in.first_item;
		push_cmd.last_item = item_in.last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_phase_odd_q <= 1'b0;
		end else if (accept && item_in.mode == irpd_pkg::MODE_RAW) begin
			raw_phase_odd_q <= item_in.last_item ? 1'b0 : ~phase_eff;
		end
	end

endmodule

@@ rtl/irpd_fifo.sv @@
`timescale 1ns / 1ps
// Short command queue between front and back ends.
// Depends on irpd_pkg.
module irpd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  irpd_pkg::cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output irpd_pkg::cmd_t pop_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	irpd_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/irpd_back.sv @@
`timescale 1ns / 1ps
// Back end: walks each command's segments into a registered output
// stage, one per cycle unless stalled. Depends on irpd_pkg, irpd_intf.
module irpd_back (
	input  logic clk,
	input  logic arst_n,
	input  irpd_pkg::cfg_t cfg,
	input  logic pop_valid,
	output logic pop_ready,
	input  irpd_pkg::cmd_t pop_cmd,
	irpd_out_if.source seg_out
);

	logic busy_q;
	irpd_pkg::cmd_t cmd_q;
	logic [irpd_pkg::SEG_W-1:0] idx_q;
	logic out_valid_q;
	logic level_q;
	logic [irpd_pkg::DUR_W-1:0] duration_q;
	logic run_end_q;

	logic emit;
	logic seg_level;
	logic [irpd_pkg::DUR_W-1:0] seg_dur;
	logic seg_last;
	logic [irpd_pkg::SEG_W-1:0] cell_off;
	logic cell_bit;

	assign emit = busy_q && (!out_valid_q || seg_out.ready);
	assign pop_ready = !busy_q || (emit && seg_last);

	assign cell_off = idx_q - irpd_pkg::SEG_CELL_FIRST;
	assign cell_bit = cmd_q.data_byte[cell_off[3:1]];

	always_comb begin
		case (cmd_q.kind)
			irpd_pkg::KIND_BYTE: begin
				seg_level = ~idx_q[0];
				if (idx_q < irpd_pkg::SEG_CELL_FIRST) begin
					seg_dur = idx_q[0] ? cfg.header_space : cfg.header_mark;
				end else if (idx_q > irpd_pkg::SEG_CELL_LAST) begin
					seg_dur = idx_q[0] ? cfg.zero_space : cfg.one_mark;
				end else if (cell_bit) begin
					seg_dur = idx_q[0] ? cfg.one_space : cfg.one_mark;
				end else begin
					seg_dur = idx_q[0] ? cfg.zero_space : cfg.zero_mark;
				end
				seg_last = idx_q == (cmd_q.last_item ? irpd_pkg::SEG_TRAILER_SPACE
					: irpd_pkg::SEG_CELL_LAST);
			end
			irpd_pkg::KIND_RAW: begin
				if (idx_q == irpd_pkg::SEG_RAW_DATA) begin
					seg_level = cmd_q.raw_level;
					seg_dur = cmd_q.raw_duration;
				end else begin
					seg_level = 1'b0;
					seg_dur = '0;
				end
				seg_last = idx_q == (cmd_q.last_item ? irpd_pkg::SEG_RAW_CLOSE
					: irpd_pkg::SEG_RAW_DATA);
			end
			irpd_pkg::KIND_WAKE: begin
				seg_level = idx_q[0];
				seg_dur = cfg.zero_mark;
				seg_last = idx_q == irpd_pkg::SEG_WAKE_LAST;
			end
			default: begin
				seg_level = 1'b0;
				seg_dur = '0;
				seg_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				busy_q <= pop_valid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (seg_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cmd_q <= pop_cmd;
			if (pop_cmd.kind == irpd_pkg::KIND_BYTE && !pop_cmd.first_item) begin
				idx_q <= irpd_pkg::SEG_CELL_FIRST;
			end else begin
				idx_q <= irpd_pkg::SEG_HDR_MARK;
			end
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
		if (emit) begin
			level_q <= seg_level;
			duration_q <= seg_dur;
			run_end_q <= seg_last;
		end
	end

	assign seg_out.valid = out_valid_q;
	assign seg_out.level = level_q;
	assign seg_out.duration = duration_q;
	assign seg_out.run_end = run_end_q;

endmodule

@@ rtl/ir_pulse_distance_encoder_core.sv @@
`timescale 1ns / 1ps
// Top level of the infrared pulse-distance encoder: register file, front end,
// command queue, back end. Depends on irpd_pkg, irpd_intf, irpd_front, irpd_fifo, irpd_back.
//
//   channel   dir  beat                                              handshake
//   item_in   in   mode, data_byte, raw_duration, first/last_item     valid/ready
//   seg_out   out  level, duration, run_end                           valid/ready
//   cfg       in   index, wdata                                       valid/ready (ready=1)
//
// The back end emits one segment per cycle into the output register while the output
// is not stalled: a byte makes 16 to 20 segments, a raw beat 1 or 2, a wake beat 11,
// a mode 3 beat none. Input beats are taken while the queue has room, so the front
// runs ahead by QUEUE_DEPTH commands while the output stalls. Reset restores the
// register defaults, clears the raw phase and empties the queue.
module ir_pulse_distance_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	irpd_in_if.sink item_in,
	irpd_out_if.source seg_out,
	irpd_cfg_if.sink cfg
);

	irpd_pkg::cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	irpd_pkg::cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	irpd_pkg::cmd_t pop_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_mark <= irpd_pkg::RST_HEADER_MARK;
			cfg_q.header_space <= irpd_pkg::RST_HEADER_SPACE;
			cfg_q.one_mark <= irpd_pkg::RST_ONE_MARK;
			cfg_q.one_space <= irpd_pkg::RST_ONE_SPACE;
			cfg_q.zero_mark <= irpd_pkg::RST_ZERO_MARK;
			cfg_q.zero_space <= irpd_pkg::RST_ZERO_SPACE;
		end else if (cfg.valid) begin
			case (cfg.index)
				irpd_pkg::CFG_HEADER_MARK: cfg_q.header_mark <= cfg.wdata;
				irpd_pkg::CFG_HEADER_SPACE: cfg_q.header_space <= cfg.wdata;
				irpd_pkg::CFG_ONE_MARK: cfg_q.one_mark <= cfg.wdata;
				irpd_pkg::CFG_ONE_SPACE: cfg_q.one_space <= cfg.wdata;
				irpd_pkg::CFG_ZERO_MARK: cfg_q.zero_mark <= cfg.wdata;
				irpd_pkg::CFG_ZERO_SPACE: cfg_q.zero_space <= cfg.wdata;
				default: ;
			endcase
		end
	end

	irpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	irpd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	irpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.seg_out   (seg_out)
	);

endmodule

@@ tb/irpd_seg_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the IR pulse-distance encoder: predicts the segment run of each
// accepted item beat and checks the output beats against it in order.
// Depends on irpd_pkg.
module irpd_seg_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [irpd_pkg::MODE_W-1:0] in_mode,
	input  logic [irpd_pkg::BYTE_W-1:0] in_byte,
	input  logic [irpd_pkg::DUR_W-1:0] in_raw,
	input  logic in_first,
	input  logic in_last,
	input  logic out_valid,
	input  logic out_ready,
	input  logic out_level,
	input  logic [irpd_pkg::DUR_W-1:0] out_duration,
	input  logic out_run_end,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [irpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [irpd_pkg::DUR_W-1:0] cfg_wdata,
	output int fail_count,
	output int pending,
	output int seg_count
);
	import irpd_pkg::*;

	localparam int WAKE_PAIRS = 5;
	localparam int MAX_RUN = 20;

	typedef struct packed {
		logic level;
		logic [DUR_W-1:0] duration;
		logic run_end;
	} seg_t;

	cfg_t timing;
	logic raw_odd;
	seg_t seg_q[$];
	seg_t run_buf[MAX_RUN];
	int run_len;
	int n_fail = 0;
	int n_seen = 0;
	int n_pending = 0;

	assign fail_count = n_fail;
	assign pending = n_pending;
	assign seg_count = n_seen;

	function automatic void add_seg(input logic lvl, input logic [DUR_W-1:0] dur);
		run_buf[run_len] = '{level: lvl, duration: dur, run_end: 1'b0};
		run_len++;
	endfunction

	function automatic void predict_run(input logic [MODE_W-1:0] m,
			input logic [BYTE_W-1:0] b, input logic [DUR_W-1:0] raw,
			input logic first_i, input logic last_i);
		run_len = 0;
		case (m)
			MODE_BYTE: begin
				if (first_i) begin
					add_seg(1'b1, timing.header_mark);
					add_seg(1'b0, timing.header_space);
				end
				for (int i = 0; i < BYTE_W; i++) begin
					if (b[i]) begin
						add_seg(1'b1, timing.one_mark);
						add_seg(1'b0, timing.one_space);
					end else begin
						add_seg(1'b1, timing.zero_mark);
						add_seg(1'b0, timing.zero_space);
					end
				end
				if (last_i) begin
					add_seg(1'b1, timing.one_mark);
					add_seg(1'b0, timing.zero_space);
				end
			end
			MODE_RAW: begin
				if (first_i)
					raw_odd = 1'b0;
				add_seg(~raw_odd, raw);
				raw_odd = ~raw_odd;
				if (last_i) begin
					add_seg(1'b0, '0);
					raw_odd = 1'b0;
				end
			end
			MODE_WAKE: begin
				add_seg(1'b0, timing.zero_mark);
				for (int i = 0; i < WAKE_PAIRS; i++) begin
					add_seg(1'b1, timing.zero_mark);
					add_seg(1'b0, timing.zero_mark);
				end
			end
			default: ;
		endcase
		for (int i = 0; i < run_len; i++)
			seg_q.push_back('{level: run_buf[i].level, duration: run_buf[i].duration,
				run_end: (i == run_len - 1)});
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		seg_t want;
		if (!arst_n) begin
			timing = '{header_mark: RST_HEADER_MARK, header_space: RST_HEADER_SPACE,
				one_mark: RST_ONE_MARK, one_space: RST_ONE_SPACE,
				zero_mark: RST_ZERO_MARK, zero_space: RST_ZERO_SPACE};
			raw_odd = 1'b0;
			seg_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEADER_MARK: timing.header_mark = cfg_wdata;
					CFG_HEADER_SPACE: timing.header_space = cfg_wdata;
					CFG_ONE_MARK: timing.one_mark = cfg_wdata;
					CFG_ONE_SPACE: timing.one_space = cfg_wdata;
					CFG_ZERO_MARK: timing.zero_mark = cfg_wdata;
					CFG_ZERO_SPACE: timing.zero_space = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				n_seen++;
				if (seg_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected segment beat, actual level=%0b duration=%0d run_end=%0b",
						$time, out_level, out_duration, out_run_end);
				end else begin
					want = seg_q.pop_front();
					if (out_level !== want.level) begin
						n_fail++;
						$display("%0t: level mismatch, expected %0b actual %0b",
							$time, want.level, out_level);
					end
					if (out_duration !== want.duration) begin
						n_fail++;
						$display("%0t: duration mismatch, expected %0d actual %0d",
							$time, want.duration, out_duration);
					end
					if (out_run_end !== want.run_end) begin
						n_fail++;
						$display("%0t: run_end mismatch, expected %0b actual %0b",
							$time, want.run_end, out_run_end);
					end
				end
			end
			if (in_valid && in_ready)
				predict_run(in_mode, in_byte, in_raw, in_first, in_last);
		end
		n_pending = seg_q.size();
	end

endmodule

@@ tb/ir_pulse_distance_encoder_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for ir_pulse_distance_encoder_core: clock, reset, item and register
// stimulus, output back-pressure and the verdict. Depends on irpd_pkg, irpd_intf,
// irpd_seg_checker and the encoder RTL.
module ir_pulse_distance_encoder_core_tb;
	import irpd_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_PCT = 22;

	logic clk = 1'b0;
	logic arst_n;
	bit idle_on = 1'b1;
	bit hold_off_go = 1'b0;
	int cycle_count = 0;
	int n_items = 0;
	int n_ignored = 0;
	int n_writes = 0;
	int n_settings = 0;
	int fail_count;
	int pending;
	int seg_count;
	cfg_t timing_set;

	irpd_in_if item_if ();
	irpd_out_if seg_if ();
	irpd_cfg_if cfg_if ();

	always #5 clk = ~clk;

	ir_pulse_distance_encoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_if),
		.seg_out(seg_if),
		.cfg(cfg_if)
	);

	irpd_seg_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item_if.valid),
		.in_ready(item_if.ready),
		.in_mode(item_if.mode),
		.in_byte(item_if.data_byte),
		.in_raw(item_if.raw_duration),
		.in_first(item_if.first_item),
		.in_last(item_if.last_item),
		.out_valid(seg_if.valid),
		.out_ready(seg_if.ready),
		.out_level(seg_if.level),
		.out_duration(seg_if.duration),
		.out_run_end(seg_if.run_end),
		.cfg_valid(cfg_if.valid),
		.cfg_ready(cfg_if.ready),
		.cfg_index(cfg_if.index),
		.cfg_wdata(cfg_if.wdata),
		.fail_count(fail_count),
		.pending(pending),
		.seg_count(seg_count)
	);

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d segments outstanding", cycle_count, pending);
		$display("RESULT: ERROR");
		$finish;
	end

	// segment receiver; one long hold-off on request
	initial begin
		bit hold_off_done;
		hold_off_done = 1'b0;
		seg_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				hold_off_done = 1'b1;
				seg_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				seg_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
			input logic [DUR_W-1:0] raw, input logic first_i, input logic last_i);
		logic took;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.mode <= m;
		item_if.data_byte <= b;
		item_if.raw_duration <= raw;
		item_if.first_item <= first_i;
		item_if.last_item <= last_i;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = item_if.valid && item_if.ready;
			@(posedge clk);
		end
		if (m == MODE_UNUSED)
			n_ignored++;
		else
			n_items++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DUR_W-1:0] data);
		logic took;
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= data;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = cfg_if.valid && cfg_if.ready;
			@(posedge clk);
		end
		n_writes++;
	endtask

	// six timing registers, then a write to a spare index that must change nothing
	task automatic program_timing(input cfg_t t, input logic [CFG_INDEX_W-1:0] spare_idx);
		write_reg(CFG_HEADER_MARK, t.header_mark);
		write_reg(CFG_HEADER_SPACE, t.header_space);
		write_reg(CFG_ONE_MARK, t.one_mark);
		write_reg(CFG_ONE_SPACE, t.one_space);
		write_reg(CFG_ZERO_MARK, t.zero_mark);
		write_reg(CFG_ZERO_SPACE, t.zero_space);
		write_reg(spare_idx, DUR_W'($urandom));
		cfg_if.valid <= 1'b0;
		n_settings++;
	endtask

	task automatic await_drain();
		item_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed frames with random content, some loose beats
	task automatic send_frames(input int target);
		int done_cnt;
		int pick;
		int len;
		logic [MODE_W-1:0] m;
		done_cnt = 0;
		while (done_cnt < target) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = $urandom_range(4, 1);
				for (int j = 0; j < len; j++)
					send_item(MODE_BYTE, BYTE_W'($urandom), DUR_W'($urandom),
						j == 0, j == len - 1);
				done_cnt += len;
			end else if (pick < 75) begin
				len = $urandom_range(6, 1);
				for (int j = 0; j < len; j++)
					send_item(MODE_RAW, BYTE_W'($urandom), DUR_W'($urandom),
						j == 0, j == len - 1);
				done_cnt += len;
			end else if (pick < 85) begin
				send_item(MODE_WAKE, BYTE_W'($urandom), DUR_W'($urandom),
					1'($urandom), 1'($urandom));
				done_cnt++;
			end else begin
				m = MODE_W'($urandom);
				send_item(m, BYTE_W'($urandom), DUR_W'($urandom),
					1'($urandom), 1'($urandom));
				if (m != MODE_UNUSED)
					done_cnt++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.mode <= MODE_BYTE;
		item_if.data_byte <= '0;
		item_if.raw_duration <= '0;
		item_if.first_item <= 1'b0;
		item_if.last_item <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_HEADER_MARK;
		cfg_if.wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset timing
		send_item(MODE_BYTE, 8'h00, 16'h0000, 1'b1, 1'b1);
		send_item(MODE_BYTE, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
		send_item(MODE_BYTE, 8'hA5, 16'h0000, 1'b1, 1'b0);
		send_item(MODE_BYTE, 8'h80, 16'h0000, 1'b0, 1'b0);
		send_item(MODE_BYTE, 8'h01, 16'h0000, 1'b0, 1'b1);
		send_item(MODE_RAW, 8'h00, 16'hFFFF, 1'b1, 1'b0);
		send_item(MODE_RAW, 8'h00, 16'h0000, 1'b0, 1'b0);
		send_item(MODE_RAW, 8'hFF, 16'h5A5A, 1'b0, 1'b0);
		// restart mid-frame: phase back to mark
		send_item(MODE_RAW, 8'h00, 16'h1234, 1'b1, 1'b0);
		send_item(MODE_RAW, 8'h00, 16'hA5A5, 1'b0, 1'b1);
		send_item(MODE_RAW, 8'h00, 16'h00FF, 1'b1, 1'b1);
		send_item(MODE_RAW, 8'h00, 16'hFF00, 1'b0, 1'b0);
		// wake and unused beats must leave the raw phase alone
		send_item(MODE_WAKE, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
		send_item(MODE_RAW, 8'h00, 16'h0001, 1'b0, 1'b0);
		send_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
		send_item(MODE_RAW, 8'h00, 16'h8000, 1'b0, 1'b1);
		send_item(MODE_WAKE, 8'h00, 16'h0000, 1'b0, 1'b0);
		send_item(MODE_UNUSED, 8'h00, 16'h0000, 1'b0, 1'b0);
		send_item(MODE_BYTE, 8'h3C, 16'hFFFF, 1'b0, 1'b1);
		send_frames(20);
		await_drain();

		// all zero timing, no idling, one long output hold-off
		program_timing('{default: '0}, CFG_SPARE_LO);
		idle_on = 1'b0;
		hold_off_go = 1'b1;
		send_frames(20);
		await_drain();

		idle_on = 1'b1;
		program_timing('{default: '1}, CFG_SPARE_HI);
		send_frames(20);
		await_drain();

		timing_set.header_mark = DUR_W'($urandom);
		timing_set.header_space = DUR_W'($urandom);
		timing_set.one_mark = DUR_W'($urandom);
		timing_set.one_space = DUR_W'($urandom);
		timing_set.zero_mark = DUR_W'($urandom);
		timing_set.zero_space = DUR_W'($urandom);
		program_timing(timing_set, CFG_SPARE_LO);
		send_frames(20);
		await_drain();

		$display("Covered %0d encoded beats and %0d unused-mode beats, %0d segments checked",
			n_items, n_ignored, seg_count);
		$display("over %0d register writes in %0d timing settings beyond reset, one long hold-off",
			n_writes, n_settings);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/irpd_pkg.sv
rtl/irpd_intf.sv
rtl/irpd_front.sv
rtl/irpd_fifo.sv
rtl/irpd_back.sv
rtl/ir_pulse_distance_encoder_core.sv
tb/irpd_seg_checker.sv
tb/ir_pulse_distance_encoder_core_tb.sv
